/* rtl/tcom_pkg.sv */
package tcom_pkg;

    localparam int MAX_INSNS   = 64;
    localparam int CODE_DEPTH  = MAX_INSNS + 1;
    localparam int GUEST_DEPTH = MAX_INSNS;
    localparam int CODE_AW     = (CODE_DEPTH > 1) ? $clog2(CODE_DEPTH) : 1;
    localparam int GUEST_AW    = (GUEST_DEPTH > 1) ? $clog2(GUEST_DEPTH) : 1;
    // scan index runs from 0 up to one past the last code entry
    localparam int SCAN_W      = $clog2(MAX_INSNS + 2);

    localparam int BOUND_W     = 16;
    localparam int ADDR_W      = 32;
    localparam int COUNT_W     = 7;
    localparam int IDX_W       = 7;
    localparam int OP_W        = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [OP_W-1:0] OP_WR_CODE  = 2'd0;
    localparam logic [OP_W-1:0] OP_WR_GUEST = 2'd1;
    localparam logic [OP_W-1:0] OP_C2G      = 2'd2;
    localparam logic [OP_W-1:0] OP_G2C      = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_INSN_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GUEST_BASE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_BASE  = 2'd2;

    typedef struct packed {
        logic [COUNT_W-1:0] insn_count;
        logic [ADDR_W-1:0]  guest_base;
        logic [ADDR_W-1:0]  code_base;
    } t_cfg;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [IDX_W-1:0]   entry_index;
        logic [BOUND_W-1:0] boundary_value;
        logic [ADDR_W-1:0]  query_address;
    } t_item;

    typedef struct packed {
        logic [ADDR_W-1:0] mapped_address;
        logic              found;
    } t_res;

    typedef struct packed {
        logic               we;
        logic [CODE_AW-1:0] waddr;
        logic [BOUND_W-1:0] wdata;
        logic               re;
        logic [CODE_AW-1:0] raddr;
    } t_code_port;

    typedef struct packed {
        logic                we;
        logic [GUEST_AW-1:0] waddr;
        logic [BOUND_W-1:0]  wdata;
        logic                re;
        logic [GUEST_AW-1:0] raddr;
    } t_guest_port;

endpackage

/* rtl/tcom_ifs.sv */
interface tcom_in_if;
    logic                           valid;
    logic                           ready;
    logic [tcom_pkg::OP_W-1:0]      op;
    logic [tcom_pkg::IDX_W-1:0]     entry_index;
    logic [tcom_pkg::BOUND_W-1:0]   boundary_value;
    logic [tcom_pkg::ADDR_W-1:0]    query_address;

    modport source (output valid, op, entry_index, boundary_value, query_address,
                    input ready);
    modport sink   (input valid, op, entry_index, boundary_value, query_address,
                    output ready);
endinterface

interface tcom_out_if;
    logic                        valid;
    logic                        ready;
    logic [tcom_pkg::ADDR_W-1:0] mapped_address;
    logic                        found;

    modport source (output valid, mapped_address, found, input ready);
    modport sink   (input valid, mapped_address, found, output ready);
endinterface

interface tcom_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [tcom_pkg::CFG_IDX_W-1:0]  index;
    logic [tcom_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/tcom_ram.sv */
module tcom_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/tcom_ctrl.sv */
module tcom_ctrl (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_item_valid,
    output logic                                o_item_ready,
    input  tcom_pkg::t_item                     i_item,
    input  tcom_pkg::t_cfg                      i_cfg,
    output tcom_pkg::t_code_port                o_code_port,
    input  logic [tcom_pkg::BOUND_W-1:0]        i_code_rdata,
    output tcom_pkg::t_guest_port               o_guest_port,
    input  logic [tcom_pkg::BOUND_W-1:0]        i_guest_rdata,
    output logic                                o_res_valid,
    output tcom_pkg::t_res                      o_res,
    input  logic                                i_res_ready
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_FETCH = 3'd2;
    localparam logic [2:0] S_FINAL = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    localparam int SW = tcom_pkg::SCAN_W;
    localparam int AW = tcom_pkg::ADDR_W;
    localparam int BW = tcom_pkg::BOUND_W;

    logic [2:0]    r_state, n_state;
    logic          r_c2g, n_c2g;
    logic [AW-1:0] r_d, n_d;
    logic [SW-1:0] r_k, n_k;
    logic [SW-1:0] r_pk, n_pk;
    logic          r_rv, n_rv;
    logic [SW-1:0] r_last, n_last;
    logic [BW-1:0] r_prev, n_prev;
    logic          r_hit, n_hit;
    logic [SW-1:0] r_hi, n_hi;
    logic [AW-1:0] r_acc, n_acc;
    logic [AW-1:0] r_res, n_res;
    logic          r_found, n_found;

    logic          c_accept;
    logic          c_is_write;
    logic [SW-1:0] c_n;
    logic          c_issue;
    logic [BW-1:0] c_rd16;
    logic [AW-1:0] c_rd32;
    logic          c_lt;
    logic          c_ge_prev;
    logic          c_hit_now;
    logic [SW-1:0] c_hi_now;
    logic [AW-1:0] c_gap;

    assign o_item_ready = (r_state == S_IDLE);
    assign c_accept     = i_item_valid && o_item_ready;
    assign c_is_write   = (i_item.op == tcom_pkg::OP_WR_CODE) ||
                          (i_item.op == tcom_pkg::OP_WR_GUEST);

    // counts above the table size act as a full table
    assign c_n = (32'(i_cfg.insn_count) > 32'(tcom_pkg::MAX_INSNS)) ?
                 SW'(tcom_pkg::MAX_INSNS) : SW'(i_cfg.insn_count);

    assign c_issue = (r_state == S_SCAN) && (r_k <= r_last);

    // write items go straight into the tables in the accept cycle
    always_comb begin
        o_code_port.we    = c_accept && (i_item.op == tcom_pkg::OP_WR_CODE) &&
                            (32'(i_item.entry_index) < 32'(tcom_pkg::CODE_DEPTH));
        o_code_port.waddr = tcom_pkg::CODE_AW'(i_item.entry_index);
        o_code_port.wdata = i_item.boundary_value;
        o_code_port.re    = (c_issue && r_c2g) || ((r_state == S_FETCH) && !r_c2g);
        o_code_port.raddr = (r_state == S_SCAN) ? tcom_pkg::CODE_AW'(r_k)
                                                : tcom_pkg::CODE_AW'(r_hi);

        o_guest_port.we    = c_accept && (i_item.op == tcom_pkg::OP_WR_GUEST) &&
                             (32'(i_item.entry_index) < 32'(tcom_pkg::GUEST_DEPTH));
        o_guest_port.waddr = tcom_pkg::GUEST_AW'(i_item.entry_index);
        o_guest_port.wdata = i_item.boundary_value;
        o_guest_port.re    = (c_issue && !r_c2g) ||
                             ((r_state == S_FETCH) && r_c2g && (r_hi != '0));
        o_guest_port.raddr = (r_state == S_SCAN) ? tcom_pkg::GUEST_AW'(r_k)
                                                 : tcom_pkg::GUEST_AW'(r_hi - SW'(1));
    end

    // compare the entry arriving from the table against the offset
    always_comb begin
        c_rd16    = r_c2g ? i_code_rdata : i_guest_rdata;
        c_rd32    = AW'(c_rd16);
        c_lt      = (r_d < c_rd32);
        c_ge_prev = (r_d >= AW'(r_prev));
        c_gap     = r_d - ((r_pk == '0) ? '0 : AW'(r_prev));
        if (r_c2g) begin
            c_hit_now = !r_hit && (r_pk != '0) && c_ge_prev && c_lt;
            c_hi_now  = r_pk - SW'(1);
        end else begin
            c_hit_now = !r_hit && c_lt;
            c_hi_now  = r_pk;
        end
    end

    always_comb begin
        n_state = r_state;
        n_c2g   = r_c2g;
        n_d     = r_d;
        n_k     = r_k;
        n_pk    = r_pk;
        n_rv    = r_rv;
        n_last  = r_last;
        n_prev  = r_prev;
        n_hit   = r_hit;
        n_hi    = r_hi;
        n_acc   = r_acc;
        n_res   = r_res;
        n_found = r_found;
        case (r_state)
            S_IDLE: begin
                if (c_accept) begin
                    if (c_is_write) begin
                        n_res   = '0;
                        n_found = 1'b1;
                        n_state = S_OUT;
                    end else begin
                        n_c2g  = (i_item.op == tcom_pkg::OP_C2G);
                        n_d    = (i_item.op == tcom_pkg::OP_C2G) ?
                                 i_item.query_address - i_cfg.code_base :
                                 i_item.query_address - i_cfg.guest_base;
                        n_last = (i_item.op == tcom_pkg::OP_C2G) ? c_n : c_n - SW'(1);
                        n_k    = '0;
                        n_rv   = 1'b0;
                        n_hit  = 1'b0;
                        if (c_n == '0) begin
                            n_res   = '0;
                            n_found = 1'b0;
                            n_state = S_OUT;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                end
            end
            S_SCAN: begin
                if (c_issue) begin
                    n_k  = r_k + SW'(1);
                    n_pk = r_k;
                    n_rv = 1'b1;
                end else begin
                    n_rv = 1'b0;
                end
                if (r_rv) begin
                    n_prev = c_rd16;
                    if (c_hit_now) begin
                        n_hit = 1'b1;
                        n_hi  = c_hi_now;
                        n_acc = c_gap;
                    end
                    // the last entry bounds the whole block
                    if (r_pk == r_last) begin
                        if (c_lt && (r_hit || c_hit_now)) begin
                            n_state = S_FETCH;
                        end else begin
                            n_res   = '0;
                            n_found = 1'b0;
                            n_state = S_OUT;
                        end
                    end
                end
            end
            S_FETCH: begin
                if (!r_c2g) begin
                    n_acc = r_acc + i_cfg.code_base;
                end
                n_state = S_FINAL;
            end
            S_FINAL: begin
                if (r_c2g) begin
                    n_res = i_cfg.guest_base +
                            ((r_hi == '0) ? '0 : AW'(i_guest_rdata));
                end else begin
                    n_res = r_acc + AW'(i_code_rdata);
                end
                n_found = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rv    <= 1'b0;
            r_hit   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rv    <= n_rv;
            r_hit   <= n_hit;
        end
        r_c2g   <= n_c2g;
        r_d     <= n_d;
        r_k     <= n_k;
        r_pk    <= n_pk;
        r_last  <= n_last;
        r_prev  <= n_prev;
        r_hi    <= n_hi;
        r_acc   <= n_acc;
        r_res   <= n_res;
        r_found <= n_found;
    end

    assign o_res_valid          = (r_state == S_OUT);
    assign o_res.mapped_address = r_res;
    assign o_res.found          = r_found;

endmodule

/* rtl/translated_code_offset_map_top.sv */
// offset map of one translation block: code-to-guest and guest-to-code lookups
// channels: i_in takes items (op, entry_index, boundary_value, query_address),
//   o_out returns one result (mapped_address, found) per item, i_cfg writes
//   insn_count (index 0), guest_base (index 1) and code_base (index 2)
// write items (ops 0 and 1) load the code or guest boundary table; the
//   result goes through the S_OUT state and then the output register to o_out
// queries scan the selected boundary table one entry per cycle out of a
//   ram with a registered read: n = min(insn_count, 64) active instructions,
//   a code-to-guest query reads n+1 entries and a guest-to-code query n
//   entries; on a hit, S_FETCH reads the matching entry of the other table
//   (none when a code-to-guest hit maps to the guest base itself) and
//   S_FINAL forms the result, a miss goes from the scan straight to S_OUT,
//   and any query on an empty block goes from idle straight to S_OUT
// one item is in flight at a time; i_in.ready is high only while idle, and
//   it rises in the cycle in which the previous result shows on o_out
// an output register holds the finished result, so the next item is taken
//   while a result still waits on o_out; a stalled o_out holds the result
// reset clears the control state and sets insn_count to 1 and both bases to
//   0; the tables hold nothing until written, and i_cfg is always ready
module translated_code_offset_map_top (
    input  logic     i_clk,
    input  logic     i_rst_n,
    tcom_in_if.sink  i_in,
    tcom_out_if.source o_out,
    tcom_cfg_if.sink i_cfg
);

    tcom_pkg::t_cfg          r_cfg;
    tcom_pkg::t_item         c_item;
    tcom_pkg::t_code_port    c_code_port;
    tcom_pkg::t_guest_port   c_guest_port;
    logic [tcom_pkg::BOUND_W-1:0] c_code_rdata;
    logic [tcom_pkg::BOUND_W-1:0] c_guest_rdata;
    logic                    c_res_valid;
    logic                    c_res_ready;
    tcom_pkg::t_res          c_res;
    logic                    r_ov;
    tcom_pkg::t_res          r_out;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.insn_count <= tcom_pkg::COUNT_W'(1);
            r_cfg.guest_base <= '0;
            r_cfg.code_base  <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                tcom_pkg::CFG_INSN_COUNT:
                    r_cfg.insn_count <= i_cfg.data[tcom_pkg::COUNT_W-1:0];
                tcom_pkg::CFG_GUEST_BASE:
                    r_cfg.guest_base <= i_cfg.data;
                tcom_pkg::CFG_CODE_BASE:
                    r_cfg.code_base  <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    assign c_item.op             = i_in.op;
    assign c_item.entry_index    = i_in.entry_index;
    assign c_item.boundary_value = i_in.boundary_value;
    assign c_item.query_address  = i_in.query_address;

    tcom_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item_valid  (i_in.valid),
        .o_item_ready  (i_in.ready),
        .i_item        (c_item),
        .i_cfg         (r_cfg),
        .o_code_port   (c_code_port),
        .i_code_rdata  (c_code_rdata),
        .o_guest_port  (c_guest_port),
        .i_guest_rdata (c_guest_rdata),
        .o_res_valid   (c_res_valid),
        .o_res         (c_res),
        .i_res_ready   (c_res_ready)
    );

    tcom_ram #(
        .WIDTH (tcom_pkg::BOUND_W),
        .DEPTH (tcom_pkg::CODE_DEPTH)
    ) u_code_ram (
        .i_clk   (i_clk),
        .i_we    (c_code_port.we),
        .i_waddr (c_code_port.waddr),
        .i_wdata (c_code_port.wdata),
        .i_re    (c_code_port.re),
        .i_raddr (c_code_port.raddr),
        .o_rdata (c_code_rdata)
    );

    tcom_ram #(
        .WIDTH (tcom_pkg::BOUND_W),
        .DEPTH (tcom_pkg::GUEST_DEPTH)
    ) u_guest_ram (
        .i_clk   (i_clk),
        .i_we    (c_guest_port.we),
        .i_waddr (c_guest_port.waddr),
        .i_wdata (c_guest_port.wdata),
        .i_re    (c_guest_port.re),
        .i_raddr (c_guest_port.raddr),
        .o_rdata (c_guest_rdata)
    );

    // output register: refills when it is empty or its current result is taken
    assign c_res_ready = !r_ov || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (c_res_valid && c_res_ready) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
        if (c_res_valid && c_res_ready) begin
            r_out <= c_res;
        end
    end

    assign o_out.valid          = r_ov;
    assign o_out.mapped_address = r_out.mapped_address;
    assign o_out.found          = r_out.found;

endmodule

/* rtl/tcom_chk.sv */
module tcom_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic [tcom_pkg::OP_W-1:0]     i_in_op,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [tcom_pkg::ADDR_W-1:0]   i_out_mapped_address,
    input logic                          i_out_found
);

    // one item at a time: taking an item closes the input side
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input taken again right after an item");

    // a miss always reports a zero address
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_found) |-> (i_out_mapped_address == '0))
        else $error("miss with nonzero address");

    // write items report found with a zero address when the output was free
    a_write_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && !i_out_valid &&
         ((i_in_op == tcom_pkg::OP_WR_CODE) || (i_in_op == tcom_pkg::OP_WR_GUEST)))
            |-> ##2 (i_out_valid && i_out_found && (i_out_mapped_address == '0)))
        else $error("write item result missing or wrong");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_mapped_address) && $stable(i_out_found)))
        else $error("stalled result changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind translated_code_offset_map_top tcom_chk u_tcom_chk (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .i_in_valid           (i_in.valid),
    .i_in_ready           (i_in.ready),
    .i_in_op              (i_in.op),
    .i_out_valid          (o_out.valid),
    .i_out_ready          (o_out.ready),
    .i_out_mapped_address (o_out.mapped_address),
    .i_out_found          (o_out.found)
);
